// ===== rtl/core/keypad_scan_debounce_macros.svh =====
// Assertion macros for the keypad scanner.
// Used by keypad_scan_debounce.sv; no other dependencies.
`ifndef KEYPAD_SCAN_DEBOUNCE_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define KPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kpd_pkg.sv =====
// Shared types, constants and key decode for the keypad scanner.
// No dependencies; imported by kpd_step and keypad_scan_debounce.
package kpd_pkg;

   localparam int COLUMN_COUNT = 3;
   localparam int COL_BITS     = 2;
   localparam int ROW_COUNT    = 4;
   localparam int HISTORY_LEN  = 8;
   localparam int WAIT_BITS    = 16;
   localparam int CFG_BITS     = 16;
   localparam int CHAR_BITS    = 8;

   localparam logic [CFG_BITS-1:0]    SETTLE_RESET   = CFG_BITS'(4);
   localparam logic [CFG_BITS-1:0]    DEBOUNCE_RESET = CFG_BITS'(1000);
   localparam logic [HISTORY_LEN-1:0] HIST_START     = HISTORY_LEN'(1);
   localparam logic [HISTORY_LEN-1:0] HIST_PRESSED   = {HISTORY_LEN{1'b1}};
   localparam logic [HISTORY_LEN-1:0] HIST_RELEASED  = '0;
   localparam logic [WAIT_BITS-1:0]   WAIT_MAX       = {WAIT_BITS{1'b1}};
   localparam logic [COLUMN_COUNT-1:0] DRIVE_ALL     = {COLUMN_COUNT{1'b1}};

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_STAR = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CHAR_HASH = 8'h23;

   localparam logic [COL_BITS-1:0] COL_STAR = COL_BITS'(0);
   localparam logic [COL_BITS-1:0] COL_HASH = COL_BITS'(2);

   // Register indexes on the csr port.
   typedef enum logic {
      CSR_SETTLE   = 1'b0,
      CSR_DEBOUNCE = 1'b1
   } kpd_csr_type;

   typedef enum logic [1:0] {
      PH_DETECT_SETTLE   = 2'd0,
      PH_DETECT_DEBOUNCE = 2'd1,
      PH_SCAN            = 2'd2
   } kpd_phase_type;

   typedef struct packed {
      kpd_phase_type          phase;
      logic [HISTORY_LEN-1:0] history;
      logic [COL_BITS-1:0]    column;
      logic [WAIT_BITS-1:0]   wait_count;
   } kpd_state_type;

   localparam kpd_state_type STATE_RESTART = '{
      phase:      PH_DETECT_SETTLE,
      history:    HIST_START,
      column:     '0,
      wait_count: '0
   };

   // ASCII for the key at (rows, col); multiple rows give '0'.
   function automatic logic [CHAR_BITS-1:0] decode_key(
      input logic [ROW_COUNT-1:0] rows,
      input logic [COL_BITS-1:0]  col
   );
      logic [CHAR_BITS-1:0] col_ext;
      logic [CHAR_BITS-1:0] ch;
      col_ext = CHAR_BITS'(col);
      case (rows)
         4'b0001: ch = CHAR_ZERO + col_ext + CHAR_BITS'(1);
         4'b0010: ch = CHAR_ZERO + col_ext + CHAR_BITS'(4);
         4'b0100: ch = CHAR_ZERO + col_ext + CHAR_BITS'(7);
         4'b1000: begin
            if (col == COL_STAR)      ch = CHAR_STAR;
            else if (col == COL_HASH) ch = CHAR_HASH;
            else                      ch = CHAR_ZERO;
         end
         default: ch = CHAR_ZERO;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/keypad_scan_debounce.sv =====
// Top level of the 4x3 keypad scanner: state, config and result registers.
// Depends on kpd_pkg, kpd_step and keypad_scan_debounce_macros.svh.
// An accepted item's result reaches the rsp side in the next cycle.
// Throughput: one item per cycle unless rsp stalls a pending result; the tick
// logic sits between the state registers and a single result register that refills as it drains.
// Reset (synchronous, active high): settle 4, debounce 1000, detect settle,
// history 0x01, column 0, wait 0, result register empty.
`include "keypad_scan_debounce_macros.svh"

module keypad_scan_debounce
   import kpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input items: one tick of row levels
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ROW_COUNT-1:0]    req_row_levels,
   // result items: column drive and decoded key
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COLUMN_COUNT-1:0] rsp_column_drive,
   output logic                    rsp_key_valid,
   output logic [CHAR_BITS-1:0]    rsp_key_char,
   // configuration writes
   input  logic                    csr_write_en,
   input  logic                    csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   kpd_state_type          state_ff, state_in;
   logic [CFG_BITS-1:0]    settle_ff, debounce_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_COUNT-1:0] drive_ff, drive_in;
   logic                   key_valid_ff, key_valid_in;
   logic [CHAR_BITS-1:0]   key_char_ff, key_char_in;
   logic                   req_accept;
   logic                   rsp_accept;

   // The result register takes a new item whenever it is empty or being
   // drained this cycle, so the input side only stalls when the result
   // side stalls with a result pending.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;

   // Config registers; the user must write them only while idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff   <= SETTLE_RESET;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_write_en) begin
         case (kpd_csr_type'(csr_index))
            CSR_SETTLE:   settle_ff   <= csr_wdata;
            CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            default:      settle_ff   <= settle_ff;
         endcase
      end
   end

   // All per-tick work: wait counter, history shift, column walk, decode.
   kpd_step u_step (
      .state          (state_ff),
      .settle_ticks   (settle_ff),
      .debounce_ticks (debounce_ff),
      .row_levels     (req_row_levels),
      .state_next     (state_in),
      .column_drive   (drive_in),
      .key_valid      (key_valid_in),
      .key_char       (key_char_in)
   );

   // Scanner state advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESTART;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register: loads on accept, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)      rsp_valid_in = 1'b1;
      else if (rsp_accept) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         drive_ff     <= drive_in;
         key_valid_ff <= key_valid_in;
         key_char_ff  <= key_char_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_drive = drive_ff;
   assign rsp_key_valid    = key_valid_ff;
   assign rsp_key_char     = key_char_ff;

   // A reported key always comes from exactly one driven column.
   `KPD_ASSERT_IMP(a_key_onehot_drive, clock, reset,
      rsp_valid_ff && key_valid_ff, $onehot(drive_ff),
      "key reported without a single driven column")
   // No key means a zero character.
   `KPD_ASSERT_IMP(a_no_key_zero_char, clock, reset,
      rsp_valid_ff && !key_valid_ff, key_char_ff == '0,
      "character set without a key")
   // Every accepted item leaves a result behind.
   `KPD_ASSERT_NXT(a_accept_fills, clock, reset,
      req_accept, rsp_valid_ff,
      "accepted item produced no result")
   // After a key is reported detection starts over.
   `KPD_ASSERT_NXT(a_key_restarts, clock, reset,
      req_accept && key_valid_in,
      state_ff.phase == PH_DETECT_SETTLE && state_ff.history == HIST_START,
      "detection not restarted after key")

endmodule

// ===== rtl/core/kpd_step.sv =====
// One tick of the scanner: next state and outputs from state and rows.
// Depends on kpd_pkg.
module kpd_step
   import kpd_pkg::*;
(
   input  kpd_state_type          state,
   input  logic [CFG_BITS-1:0]    settle_ticks,
   input  logic [CFG_BITS-1:0]    debounce_ticks,
   input  logic [ROW_COUNT-1:0]   row_levels,
   output kpd_state_type          state_next,
   output logic [COLUMN_COUNT-1:0] column_drive,
   output logic                   key_valid,
   output logic [CHAR_BITS-1:0]   key_char
);

   logic [CFG_BITS-1:0]    limit;
   logic                   wait_done;
   logic [WAIT_BITS-1:0]   wait_next;
   logic                   any_row;
   logic [HISTORY_LEN-1:0] hist_shift;

   // Saturating wait: ends when the count reaches the limit or its maximum.
   assign limit     = (state.phase == PH_DETECT_DEBOUNCE) ? debounce_ticks : settle_ticks;
   assign wait_done = (state.wait_count >= limit) || (state.wait_count == WAIT_MAX);
   assign wait_next = wait_done ? '0 : state.wait_count + WAIT_BITS'(1);
   assign any_row   = |row_levels;
   assign hist_shift = {state.history[HISTORY_LEN-2:0], any_row};

   always_comb begin
      state_next   = state;
      column_drive = '0;
      key_valid    = 1'b0;
      key_char     = '0;
      case (state.phase)
         PH_SCAN: begin
            if (state.column >= COL_BITS'(COLUMN_COUNT)) begin
               state_next = STATE_RESTART;
            end else begin
               column_drive          = COLUMN_COUNT'(1) << state.column;
               state_next.wait_count = wait_next;
               if (wait_done) begin
                  if (any_row) begin
                     key_valid  = 1'b1;
                     key_char   = decode_key(row_levels, state.column);
                     state_next = STATE_RESTART;
                  end else if (state.column == COL_BITS'(COLUMN_COUNT - 1)) begin
                     state_next = STATE_RESTART;
                  end else begin
                     state_next.column = state.column + COL_BITS'(1);
                  end
               end
            end
         end
         PH_DETECT_DEBOUNCE: begin
            column_drive          = DRIVE_ALL;
            state_next.wait_count = wait_next;
            if (wait_done) begin
               if (hist_shift == HIST_PRESSED) begin
                  state_next.phase      = PH_SCAN;
                  state_next.column     = '0;
                  state_next.wait_count = '0;
                  state_next.history    = HIST_START;
               end else if (hist_shift == HIST_RELEASED) begin
                  state_next = STATE_RESTART;
               end else begin
                  state_next.history = hist_shift;
               end
            end
         end
         default: begin
            // detect settle; the unused code behaves the same
            column_drive          = DRIVE_ALL;
            state_next.phase      = PH_DETECT_SETTLE;
            state_next.wait_count = wait_next;
            if (wait_done) begin
               state_next.phase   = PH_DETECT_DEBOUNCE;
               state_next.history = HIST_START;
            end
         end
      endcase
   end

endmodule
